### hdl/rgpb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgpb_pkg: shared types and constants for reduced grid point bracketing
// Beat formats, register indexes, fixed-point constants and the row point
// count function used by the top level.
// ----------------------------------------------------------------------------
package rgpb_pkg;

    localparam int MAX_ROWS        = 4096;
    localparam int ANGLE_FRAC_BITS = 20;
    localparam int WEIGHT_BITS     = 16;

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_ROW_COUNT   = 2'd0;
    localparam logic [1:0] CFG_LAYOUT_MODE = 2'd1;
    localparam logic [1:0] CFG_BASE_POINTS = 2'd2;

    // Layout modes.
    localparam logic MODE_REGULAR    = 1'b0;
    localparam logic MODE_OCTAHEDRAL = 1'b1;

    // Ninety degrees in angle units.
    localparam logic signed [28:0] QUARTER = 29'sd94371840;

    // Reciprocals for division by constants. Each quotient is exact over the
    // full range of its dividend.
    localparam logic [23:0] RECIP_90     = 24'd11930465;   // ceil(2^30 / 90)
    localparam int          RECIP_90_SH  = 30;
    localparam logic [12:0] RECIP_360S   = 13'd5826;       // ceil(2^21 / 360)
    localparam int          RECIP_360S_SH = 21;
    localparam logic [27:0] RECIP_360L   = 28'd190887436;  // ceil(2^36 / 360)
    localparam int          RECIP_360L_SH = 36;
    localparam logic [8:0]  DEG_360      = 9'd360;
    // Six full turns in whole degrees, enough to make any degree count positive.
    localparam logic [13:0] DEG_OFFSET   = 14'd2160;

    typedef struct packed {
        logic signed [27:0] latitude;
        logic signed [31:0] longitude;
    } t_in_beat;

    typedef struct packed {
        logic [11:0] north_row;
        logic [11:0] south_row;
        logic [16:0] north_west_index;
        logic [16:0] north_east_index;
        logic [15:0] north_fraction;
        logic [16:0] south_west_index;
        logic [16:0] south_east_index;
        logic [15:0] south_fraction;
    } t_out_beat;

    // Load enables of the four longitude stages inside one lane.
    typedef struct packed {
        logic s6;
        logic s7;
        logic s8;
        logic s9;
    } t_lane_en;

    // Point count of a row: fixed in regular mode, and growing by four per
    // row away from the nearest pole in octahedral mode. Zero counts as one.
    function automatic logic [16:0] row_points(input logic [11:0] row,
                                               input logic [12:0] rows,
                                               input logic        mode,
                                               input logic [15:0] base);
        logic [12:0] half;
        logic [12:0] pole_dist;
        logic [16:0] n;
        half = rows >> 1;
        if ({1'b0, row} < half) begin
            pole_dist = {1'b0, row};
        end else begin
            pole_dist = rows - 13'd1 - {1'b0, row};
        end
        n = {1'b0, base};
        if (mode == MODE_OCTAHEDRAL) begin
            n = n + {2'b00, pole_dist[11:0], 2'b00};
        end
        if (n == 17'd0) begin
            n = 17'd1;
        end
        return n;
    endfunction

endpackage
`default_nettype wire

### hdl/rgpb_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgpb_lane: longitude placement within one row
// Four register stages: product of longitude and point count, west index,
// remainder and east index, west fraction.
// ----------------------------------------------------------------------------
module rgpb_lane (
    input  wire logic              i_clk,
    input  wire rgpb_pkg::t_lane_en i_en,
    input  wire logic [28:0]       i_lon,
    input  wire logic [16:0]       i_points,
    output logic [16:0]            o_west,
    output logic [16:0]            o_east,
    output logic [15:0]            o_fraction
);

    logic [45:0] r6_prod;
    logic [16:0] r6_n;
    logic [25:0] r7_x;
    logic [16:0] r7_w;
    logic [19:0] r7_low;
    logic [16:0] r7_n;
    logic [24:0] r8_y;
    logic [16:0] r8_w;
    logic [16:0] r8_e;
    logic [16:0] r9_w;
    logic [16:0] r9_e;
    logic [15:0] r9_f;

    logic [53:0] n_wprod;
    logic [25:0] n_remdeg;
    logic [28:0] n_rem;
    logic [17:0] n_wp1;
    logic [52:0] n_fprod;

    always_comb begin
        n_wprod  = 54'(r6_prod[45:20]) * 54'(rgpb_pkg::RECIP_360L);
        n_remdeg = r7_x - 26'(r7_w) * 26'(rgpb_pkg::DEG_360);
        n_rem    = {n_remdeg[8:0], r7_low};
        n_wp1    = {1'b0, r7_w} + 18'd1;
        n_fprod  = 53'(r8_y) * 53'(rgpb_pkg::RECIP_360L);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s6) begin
            r6_prod <= 46'(i_lon) * 46'(i_points);
            r6_n    <= i_points;
        end
        if (i_en.s7) begin
            r7_x   <= r6_prod[45:20];
            r7_w   <= n_wprod[52:rgpb_pkg::RECIP_360L_SH];
            r7_low <= r6_prod[19:0];
            r7_n   <= r6_n;
        end
        if (i_en.s8) begin
            r8_y <= n_rem[28:4];
            r8_w <= r7_w;
            r8_e <= (n_wp1 >= {1'b0, r7_n}) ? 17'd0 : n_wp1[16:0];
        end
        if (i_en.s9) begin
            r9_w <= r8_w;
            r9_e <= r8_e;
            r9_f <= n_fprod[51:rgpb_pkg::RECIP_360L_SH];
        end
    end

    assign o_west     = r9_w;
    assign o_east     = r9_e;
    assign o_fraction = r9_f;

endmodule
`default_nettype wire

### hdl/reduced_grid_point_bracketing.sv
`default_nettype none
// ----------------------------------------------------------------------------
// reduced_grid_point_bracketing: locate a query on a reduced lat/lon grid
// Finds the north and south bracketing rows of a query latitude and, in each
// row, the west and east point indices and the west fraction of the longitude.
// ----------------------------------------------------------------------------
// A user sees a nine-stage pipeline that takes one beat per clock while the
// output side does not stall, and gives one result beat per input beat, in
// order, from the last stage register. The depth is
// set by the multipliers, which are spread over the stages so that none holds
// more than one wide product (latitude times row count, the divide by ninety
// degrees, the longitude times point count, and two divides by 360 degrees done
// as reciprocal multiplies; a narrow divide of the whole degrees by 360 shares
// the first stage). Every
// stage holds a valid bit, and a stage whose successor is empty or moving takes
// a new beat, so bubbles close up and a waiting result does not block intake
// until the pipeline is full. Stages one to three bracket the latitude, stage
// four picks the rows, stage five finds the point count of each row, and two
// identical lanes place the longitude in the north and south rows. The
// configuration registers feed the stages directly and are to be written only
// while the block is empty; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module reduced_grid_point_bracketing (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [15:0]          i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire rgpb_pkg::t_in_beat   i_data,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output rgpb_pkg::t_out_beat       o_data
);

    localparam int NUM_STAGES = 9;

    // Configuration registers.
    logic [12:0] r_row_count;
    logic        r_layout_mode;
    logic [15:0] r_base_points;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count   <= 13'd16;
            r_layout_mode <= rgpb_pkg::MODE_OCTAHEDRAL;
            r_base_points <= 16'd20;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rgpb_pkg::CFG_ROW_COUNT:   r_row_count   <= i_cfg_data[12:0];
                rgpb_pkg::CFG_LAYOUT_MODE: r_layout_mode <= i_cfg_data[0];
                rgpb_pkg::CFG_BASE_POINTS: r_base_points <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Row count clamped to the supported range; zero works as one row.
    logic [12:0] rows;
    always_comb begin
        if (r_row_count == 13'd0) begin
            rows = 13'd1;
        end else if (r_row_count > 13'(rgpb_pkg::MAX_ROWS)) begin
            rows = 13'(rgpb_pkg::MAX_ROWS);
        end else begin
            rows = r_row_count;
        end
    end

    // Valid bits and the ready chain. A stage loads when it is empty or when
    // the stage after it moves on in the same cycle.
    logic [NUM_STAGES:1] r_v;
    logic [NUM_STAGES:1] ld;

    always_comb begin
        ld[NUM_STAGES] = !r_v[NUM_STAGES] || !i_stall;
        for (int s = NUM_STAGES - 1; s >= 1; s--) begin
            ld[s] = !r_v[s] || ld[s + 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ld[1]) begin
                r_v[1] <= i_valid;
            end
            for (int s = 2; s <= NUM_STAGES; s++) begin
                if (ld[s]) begin
                    r_v[s] <= r_v[s - 1];
                end
            end
        end
    end

    assign o_stall = !ld[1];
    assign o_valid = r_v[NUM_STAGES];

    // Stage 1: distance from the north pole times the row count, and the whole
    // degrees of the longitude made positive with a first quotient by 360.
    logic signed [28:0] n_dist;
    logic [13:0]        n_hx;
    logic [26:0]        n_hprod;
    logic signed [42:0] r1_q;
    logic [13:0]        r1_hx;
    logic [5:0]         r1_hq;
    logic [19:0]        r1_low;

    always_comb begin
        n_dist  = rgpb_pkg::QUARTER - 29'(i_data.latitude);
        n_hx    = 14'({{2{i_data.longitude[31]}}, i_data.longitude[31:20]})
                  + rgpb_pkg::DEG_OFFSET;
        n_hprod = 27'(n_hx) * 27'(rgpb_pkg::RECIP_360S);
    end

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r1_q   <= 43'(n_dist) * $signed({30'd0, rows});
            r1_hx  <= n_hx;
            r1_hq  <= n_hprod[26:rgpb_pkg::RECIP_360S_SH];
            r1_low <= i_data.longitude[19:0];
        end
    end

    // Stage 2: scaled latitude offset for the divide by ninety degrees, and
    // the wrapped longitude in [0, 360) degrees.
    logic        n_qpos;
    logic [42:0] n_qm1;
    logic [13:0] n_ldeg;
    logic        r2_qpos;
    logic [19:0] r2_t;
    logic [28:0] r2_l;

    always_comb begin
        n_qpos = !r1_q[42] && (r1_q != 43'sd0);
        n_qm1  = r1_q - 43'sd1;
        n_ldeg = r1_hx - 14'(r1_hq) * 14'(rgpb_pkg::DEG_360);
    end

    always_ff @(posedge i_clk) begin
        if (ld[2]) begin
            r2_qpos <= n_qpos;
            r2_t    <= n_qpos ? n_qm1[39:20] : 20'd0;
            r2_l    <= {n_ldeg[8:0], r1_low};
        end
    end

    // Stage 3: quotient by ninety degrees.
    logic [43:0] n_mprod;
    logic        r3_qpos;
    logic [13:0] r3_m;
    logic [28:0] r3_l;

    assign n_mprod = 44'(r2_t) * 44'(rgpb_pkg::RECIP_90);

    always_ff @(posedge i_clk) begin
        if (ld[3]) begin
            r3_qpos <= r2_qpos;
            r3_m    <= n_mprod[43:rgpb_pkg::RECIP_90_SH];
            r3_l    <= r2_l;
        end
    end

    // Stage 4: count of rows north of the query, then the bracketing rows.
    // Queries beyond the first or last row clamp both rows to that end.
    logic [14:0] n_m1;
    logic [13:0] n_k;
    logic [11:0] n_north;
    logic [11:0] n_south;
    logic [11:0] r4_north;
    logic [11:0] r4_south;
    logic [28:0] r4_l;

    always_comb begin
        n_m1 = {1'b0, r3_m} + 15'd1;
        n_k  = r3_qpos ? n_m1[14:1] : 14'd0;
        if (n_k >= {1'b0, rows}) begin
            n_north = 12'(rows - 13'd1);
            n_south = 12'(rows - 13'd1);
        end else if (n_k == 14'd0) begin
            n_north = 12'd0;
            n_south = 12'd0;
        end else begin
            n_south = n_k[11:0];
            n_north = 12'(n_k - 14'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[4]) begin
            r4_north <= n_north;
            r4_south <= n_south;
            r4_l     <= r3_l;
        end
    end

    // Stage 5: point count of each row.
    logic [11:0] r5_north;
    logic [11:0] r5_south;
    logic [16:0] r5_north_n;
    logic [16:0] r5_south_n;
    logic [28:0] r5_l;

    always_ff @(posedge i_clk) begin
        if (ld[5]) begin
            r5_north   <= r4_north;
            r5_south   <= r4_south;
            r5_north_n <= rgpb_pkg::row_points(r4_north, rows, r_layout_mode,
                                               r_base_points);
            r5_south_n <= rgpb_pkg::row_points(r4_south, rows, r_layout_mode,
                                               r_base_points);
            r5_l       <= r4_l;
        end
    end

    // Row indices ride alongside the lanes through stages 6 to 9.
    logic [11:0] r6_north, r7_north, r8_north, r9_north;
    logic [11:0] r6_south, r7_south, r8_south, r9_south;

    always_ff @(posedge i_clk) begin
        if (ld[6]) begin
            r6_north <= r5_north;
            r6_south <= r5_south;
        end
        if (ld[7]) begin
            r7_north <= r6_north;
            r7_south <= r6_south;
        end
        if (ld[8]) begin
            r8_north <= r7_north;
            r8_south <= r7_south;
        end
        if (ld[9]) begin
            r9_north <= r8_north;
            r9_south <= r8_south;
        end
    end

    rgpb_pkg::t_lane_en lane_en;
    assign lane_en = '{s6: ld[6], s7: ld[7], s8: ld[8], s9: ld[9]};

    logic [16:0] north_w, north_e, south_w, south_e;
    logic [15:0] north_f, south_f;

    rgpb_lane u_north_lane (
        .i_clk      (i_clk),
        .i_en       (lane_en),
        .i_lon      (r5_l),
        .i_points   (r5_north_n),
        .o_west     (north_w),
        .o_east     (north_e),
        .o_fraction (north_f)
    );

    rgpb_lane u_south_lane (
        .i_clk      (i_clk),
        .i_en       (lane_en),
        .i_lon      (r5_l),
        .i_points   (r5_south_n),
        .o_west     (south_w),
        .o_east     (south_e),
        .o_fraction (south_f)
    );

    always_comb begin
        o_data.north_row        = r9_north;
        o_data.south_row        = r9_south;
        o_data.north_west_index = north_w;
        o_data.north_east_index = north_e;
        o_data.north_fraction   = north_f;
        o_data.south_west_index = south_w;
        o_data.south_east_index = south_e;
        o_data.south_fraction   = south_f;
    end

endmodule
`default_nettype wire
